// ===== design/lpcd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpcd_pkg
// Shared types and constants for the length-prefixed command deframer.
// ----------------------------------------------------------------------------
package lpcd_pkg;

    localparam int MAX_FRAME = 32;
    localparam int ADDR_W    = $clog2(MAX_FRAME);
    localparam int LEN_W     = $clog2(MAX_FRAME + 1);

    localparam logic [7:0] START_CHAR_RST = 8'd37;
    localparam logic [7:0] PRINT_CODE_RST = 8'd112;
    localparam logic [7:0] FLUSH_CODE_RST = 8'd114;

    typedef enum logic [1:0] {
        CFG_START_CHAR = 2'd0,
        CFG_PRINT_CODE = 2'd1,
        CFG_FLUSH_CODE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_PRINT   = 2'd0,
        KIND_FLUSH   = 2'd1,
        KIND_UNKNOWN = 2'd2,
        KIND_LEN_ERR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_LENGTH,
        ST_READ,
        ST_FETCH,
        ST_LOAD,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [7:0] start_char;
        logic [7:0] print_code;
        logic [7:0] flush_code;
    } cfg_t;

endpackage
`default_nettype wire

// ===== design/lpcd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpcd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lpcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule
`default_nettype wire

// ===== design/lpcd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpcd_ctrl
// Frame sequencer: hunts for the start character, stores the message in the
// frame RAM, decodes the command and replays the payload from the RAM.
// ----------------------------------------------------------------------------
module lpcd_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lpcd_pkg::cfg_t      cfg,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_rx_byte,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_result_kind,
    output logic [7:0]               m_payload_byte,
    output logic                     m_payload_valid,
    output logic                     m_last
);

    localparam int LEN_W  = lpcd_pkg::LEN_W;
    localparam int ADDR_W = lpcd_pkg::ADDR_W;

    lpcd_pkg::state_t  state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [7:0]        cmd_reg, cmd_next;
    lpcd_pkg::kind_t   kind_reg, kind_next;
    logic [7:0]        byte_reg, byte_next;
    logic              pvalid_reg, pvalid_next;
    logic              last_reg, last_next;

    logic              s_fire;
    logic              ram_we;
    logic [7:0]        ram_rdata;
    logic [LEN_W-1:0]  count_inc;
    logic [LEN_W-1:0]  idx_inc;
    logic [7:0]        cmd_now;
    logic              len_bad;

    assign s_fire    = s_valid && s_ready;
    assign count_inc = count_reg + LEN_W'(1);
    assign idx_inc   = idx_reg + LEN_W'(1);
    assign len_bad   = (s_rx_byte == 8'd0) ||
                       ({1'b0, s_rx_byte} > 9'(lpcd_pkg::MAX_FRAME));
    // The command byte is the first message byte, kept aside as it arrives.
    assign cmd_now   = (count_reg == '0) ? s_rx_byte : cmd_reg;
    assign ram_we    = s_fire && (state_reg == lpcd_pkg::ST_READ);

    lpcd_ram #(
        .WIDTH(8),
        .DEPTH(lpcd_pkg::MAX_FRAME)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(count_reg[ADDR_W-1:0]),
        .wr_data(s_rx_byte),
        .rd_addr(idx_reg[ADDR_W-1:0]),
        .rd_data(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpcd_pkg::ST_HUNT;
            len_reg   <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            count_reg <= count_next;
        end
        idx_reg    <= idx_next;
        cmd_reg    <= cmd_next;
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        pvalid_reg <= pvalid_next;
        last_reg   <= last_next;
    end

    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        cmd_next    = cmd_reg;
        kind_next   = kind_reg;
        byte_next   = byte_reg;
        pvalid_next = pvalid_reg;
        last_next   = last_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;

        unique case (state_reg)
            lpcd_pkg::ST_HUNT: begin
                s_ready = 1'b1;
                if (s_fire && (s_rx_byte == cfg.start_char)) begin
                    state_next = lpcd_pkg::ST_LENGTH;
                end
            end
            lpcd_pkg::ST_LENGTH: begin
                s_ready = 1'b1;
                if (s_fire) begin
                    if (len_bad) begin
                        kind_next   = lpcd_pkg::KIND_LEN_ERR;
                        byte_next   = 8'd0;
                        pvalid_next = 1'b0;
                        last_next   = 1'b1;
                        state_next  = lpcd_pkg::ST_RESULT;
                    end else begin
                        len_next   = s_rx_byte[LEN_W-1:0];
                        count_next = '0;
                        state_next = lpcd_pkg::ST_READ;
                    end
                end
            end
            lpcd_pkg::ST_READ: begin
                s_ready = 1'b1;
                if (s_fire) begin
                    count_next = count_inc;
                    cmd_next   = cmd_now;
                    if (count_inc >= len_reg) begin
                        byte_next   = 8'd0;
                        pvalid_next = 1'b0;
                        last_next   = 1'b1;
                        state_next  = lpcd_pkg::ST_RESULT;
                        // Flush takes precedence when both codes are equal.
                        if (cmd_now == cfg.flush_code) begin
                            kind_next = lpcd_pkg::KIND_FLUSH;
                        end else if (cmd_now == cfg.print_code) begin
                            kind_next = lpcd_pkg::KIND_PRINT;
                            if (len_reg > LEN_W'(1)) begin
                                idx_next   = LEN_W'(1);
                                state_next = lpcd_pkg::ST_FETCH;
                            end
                        end else begin
                            kind_next = lpcd_pkg::KIND_UNKNOWN;
                        end
                    end
                end
            end
            lpcd_pkg::ST_FETCH: begin
                // Read address is presented this cycle; data lands next cycle.
                state_next = lpcd_pkg::ST_LOAD;
            end
            lpcd_pkg::ST_LOAD: begin
                kind_next   = lpcd_pkg::KIND_PRINT;
                byte_next   = ram_rdata;
                pvalid_next = 1'b1;
                last_next   = (idx_inc == len_reg);
                state_next  = lpcd_pkg::ST_RESULT;
            end
            lpcd_pkg::ST_RESULT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (last_reg) begin
                        state_next = lpcd_pkg::ST_HUNT;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = lpcd_pkg::ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = lpcd_pkg::ST_HUNT;
            end
        endcase
    end

    assign m_result_kind   = kind_reg;
    assign m_payload_byte  = byte_reg;
    assign m_payload_valid = pvalid_reg;
    assign m_last          = last_reg;

endmodule
`default_nettype wire

// ===== design/length_prefixed_command_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_command_deframer
// Byte-stream deframer for start/length/command frames with a payload store.
// ----------------------------------------------------------------------------
// Received bytes enter one word at a time on the s_ channel. A frame is the
// start character, a length byte (1 to 32) and that many message bytes, the
// first of which is the command. Results leave on the m_ channel: a run of
// payload words for a print command (a single word with m_payload_valid low
// if it has no payload), or a single flush, unknown-command or length-error
// word, each run closed by m_last. Input words are taken back to back while
// a frame is being received. After the final message byte, a single-word
// result is valid on the next cycle; a print run fetches each payload word
// from the frame RAM (fetch, RAM read, load into the output register), the
// next only after the receiver has taken the previous one. No input is taken
// while results are being delivered. If the receiver stalls, the output
// register holds its word and the sequencer waits. Configuration words on
// cfg_ are taken at once. Reset returns the sequencer to hunting and restores
// the default start, print and flush codes; the frame RAM is not cleared.
// ----------------------------------------------------------------------------
module length_prefixed_command_deframer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_result_kind,
    output logic [7:0]      m_payload_byte,
    output logic            m_payload_valid,
    output logic            m_last
);

    lpcd_pkg::cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                lpcd_pkg::CFG_START_CHAR: cfg_next.start_char = cfg_data;
                lpcd_pkg::CFG_PRINT_CODE: cfg_next.print_code = cfg_data;
                lpcd_pkg::CFG_FLUSH_CODE: cfg_next.flush_code = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_char <= lpcd_pkg::START_CHAR_RST;
            cfg_reg.print_code <= lpcd_pkg::PRINT_CODE_RST;
            cfg_reg.flush_code <= lpcd_pkg::FLUSH_CODE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lpcd_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_payload_byte (m_payload_byte),
        .m_payload_valid(m_payload_valid),
        .m_last         (m_last)
    );

endmodule
`default_nettype wire
